// ----- hdl/atapi_pio_reply_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the atapi pio reply sequencer
// checker properties share clock, reset and report form through these
// ----------------------------------------------------------------------------
`ifndef ATAPI_PIO_REPLY_SEQUENCER_ASSERT_SVH
`define ATAPI_PIO_REPLY_SEQUENCER_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define APIO_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication under synchronous active-low reset
`define APIO_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- hdl/apio_pkg.sv -----
// ----------------------------------------------------------------------------
// apio_pkg
// shared types and constants of the atapi pio reply sequencer
// ----------------------------------------------------------------------------
package apio_pkg;

    localparam int MAX_SECTOR_BYTES = 4096;
    localparam int MIN_SECTOR_BYTES = 512;
    localparam int SECTOR_W         = 13;
    localparam int BUF_IDX_MAX      = 8191;

    localparam logic [SECTOR_W-1:0] SECTOR_RESET = 13'd2048;

    // outcome codes
    localparam logic [1:0] OUTCOME_CHUNK = 2'd0;
    localparam logic [1:0] OUTCOME_DONE  = 2'd1;
    localparam logic [1:0] OUTCOME_ERROR = 2'd2;

    // interrupt reason codes (io, cod)
    localparam logic [1:0] INT_REASON_DATA = 2'd2;
    localparam logic [1:0] INT_REASON_DONE = 2'd3;

    // mode codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    localparam logic [15:0] LIMIT_ALL_ONES = 16'hffff;
    localparam logic [15:0] LIMIT_CAPPED   = 16'hfffe;
    localparam logic [15:0] LIMIT_EVEN     = 16'hfffe;

    typedef struct packed {
        logic        mode;
        logic [23:0] total_bytes;
        logic        from_media;
        logic [31:0] start_sector;
        logic [15:0] host_byte_limit;
        logic        read_ok;
    } apio_in_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        read_issued;
        logic [31:0] read_sector;
        logic [11:0] buffer_offset;
        logic [15:0] chunk_bytes;
        logic [15:0] byte_count_out;
        logic [1:0]  int_reason;
        logic        raise_irq;
    } apio_out_t;

endpackage

// ----- hdl/atapi_pio_reply_sequencer.sv -----
// ----------------------------------------------------------------------------
// atapi_pio_reply_sequencer
// sequences the data-in phase of an atapi pio reply, one step per transaction
// ----------------------------------------------------------------------------
// A start transaction (mode 0) loads the reply length, media flag, first
// sector and host byte-count limit, then steps; a step transaction (mode 1)
// says the last chunk was consumed and steps again. Every transaction gives
// exactly one result. Throughput is one transaction per clock while the
// result channel is not stalled: the step is a handful of compares and
// subtractions between the input register and the result register, and the
// sequencer state is updated on the same edge the result is registered, so
// the next step sees it. Input is taken while a result waits, as long as the
// input register can move on. sector_bytes is to be written through
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
// The value in use is clamped to 512..4096 bytes.
// ----------------------------------------------------------------------------
module atapi_pio_reply_sequencer (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [12:0]           cfg_wr_data,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  apio_pkg::apio_in_t    s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output apio_pkg::apio_out_t   m_data
);

    // configuration register
    logic [apio_pkg::SECTOR_W-1:0] sector_bytes_reg;

    // input stage
    logic                 in_valid_reg;
    apio_pkg::apio_in_t   in_data_reg;

    // result stage
    logic                 out_valid_reg;
    apio_pkg::apio_out_t  out_data_reg;

    // sequencer state
    logic [23:0] bytes_rem_reg,  bytes_rem_next;
    logic [15:0] block_rem_reg,  block_rem_next;
    logic [12:0] buf_idx_reg,    buf_idx_next;
    logic [31:0] next_sec_reg,   next_sec_next;
    logic        media_reg,      media_next;
    logic [15:0] byte_count_reg, byte_count_next;

    apio_pkg::apio_out_t result_next;

    logic fire;

    // step fires when an item is held and the result slot is free or draining
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // ------------------------------------------------------------------
    // step logic
    // ------------------------------------------------------------------
    logic [12:0] sec;
    logic        start;
    logic [23:0] br0;
    logic        mm0;
    logic [31:0] ns0, ns1;
    logic [15:0] bc0;
    logic [15:0] blk0;
    logic [12:0] bi0, bi1;
    logic        need_read, failed;
    logic [12:0] rem;
    logic [15:0] limit, size, chunk, blk1;
    logic [16:0] bi_sum;

    always_comb begin
        // effective sector size, clamped
        sec = sector_bytes_reg;
        if (sec < 13'(apio_pkg::MIN_SECTOR_BYTES)) begin
            sec = 13'(apio_pkg::MIN_SECTOR_BYTES);
        end
        if (sec > 13'(apio_pkg::MAX_SECTOR_BYTES)) begin
            sec = 13'(apio_pkg::MAX_SECTOR_BYTES);
        end

        start = (in_data_reg.mode == apio_pkg::MODE_START);

        // state after an optional start load
        br0  = start ? in_data_reg.total_bytes     : bytes_rem_reg;
        mm0  = start ? in_data_reg.from_media      : media_reg;
        ns0  = start ? in_data_reg.start_sector    : next_sec_reg;
        bc0  = start ? in_data_reg.host_byte_limit : byte_count_reg;
        blk0 = start ? 16'd0                       : block_rem_reg;
        bi0  = start ? (in_data_reg.from_media ? sec : 13'd0) : buf_idx_reg;

        // sector refill when the buffer is used up in media mode
        need_read = mm0 && (bi0 >= sec);
        failed    = need_read && !in_data_reg.read_ok;
        ns1       = (need_read && in_data_reg.read_ok) ? ns0 + 32'd1 : ns0;
        bi1       = (need_read && in_data_reg.read_ok) ? 13'd0 : bi0;

        rem = (bi1 >= sec) ? 13'd0 : sec - bi1;

        // chunk sizing: continue the open drq block or open a new one
        limit = (bc0 == apio_pkg::LIMIT_ALL_ONES) ? apio_pkg::LIMIT_CAPPED : bc0;
        size  = br0[15:0];
        if (br0 > {8'd0, limit}) begin
            size = limit & apio_pkg::LIMIT_EVEN;
        end

        if (blk0 != 16'd0) begin
            chunk = ({3'd0, rem} > blk0) ? blk0 : {3'd0, rem};
            blk1  = blk0;
        end else begin
            blk1  = size;
            chunk = (mm0 && (size > {3'd0, rem})) ? {3'd0, rem} : size;
        end

        bi_sum = {4'd0, bi1} + {1'b0, chunk};

        // defaults: nothing moves past the start load
        bytes_rem_next  = br0;
        block_rem_next  = blk0;
        buf_idx_next    = bi0;
        next_sec_next   = ns0;
        media_next      = mm0;
        byte_count_next = bc0;

        result_next                = '0;
        result_next.int_reason     = apio_pkg::INT_REASON_DATA;

        if (br0 == 24'd0) begin
            // reply complete
            result_next.outcome    = apio_pkg::OUTCOME_DONE;
            result_next.int_reason = apio_pkg::INT_REASON_DONE;
            result_next.raise_irq  = 1'b1;
        end else begin
            result_next.read_issued = need_read;
            result_next.read_sector = need_read ? ns0 : 32'd0;
            if (failed) begin
                // read error ends the command
                result_next.outcome    = apio_pkg::OUTCOME_ERROR;
                result_next.int_reason = apio_pkg::INT_REASON_DONE;
                result_next.raise_irq  = 1'b1;
                bytes_rem_next         = 24'd0;
                block_rem_next         = 16'd0;
            end else begin
                result_next.outcome       = apio_pkg::OUTCOME_CHUNK;
                result_next.buffer_offset = bi1[11:0];
                result_next.chunk_bytes   = chunk;
                result_next.raise_irq     = (blk0 == 16'd0);
                if (blk0 == 16'd0) begin
                    byte_count_next = size;
                end
                next_sec_next  = ns1;
                bytes_rem_next = ({8'd0, chunk} > br0) ? 24'd0 : br0 - {8'd0, chunk};
                block_rem_next = (chunk > blk1) ? 16'd0 : blk1 - chunk;
                // buffer index saturates when no media refill bounds it
                buf_idx_next   = (bi_sum > 17'(apio_pkg::BUF_IDX_MAX)) ?
                                 13'(apio_pkg::BUF_IDX_MAX) : bi_sum[12:0];
            end
        end
        result_next.byte_count_out = byte_count_next;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_bytes_reg <= apio_pkg::SECTOR_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            bytes_rem_reg    <= '0;
            block_rem_reg    <= '0;
            buf_idx_reg      <= '0;
            next_sec_reg     <= '0;
            media_reg        <= 1'b0;
            byte_count_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                sector_bytes_reg <= cfg_wr_data;
            end

            // input register
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            // result register
            if (fire) begin
                out_valid_reg  <= 1'b1;
                bytes_rem_reg  <= bytes_rem_next;
                block_rem_reg  <= block_rem_next;
                buf_idx_reg    <= buf_idx_next;
                next_sec_reg   <= next_sec_next;
                media_reg      <= media_next;
                byte_count_reg <= byte_count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= result_next;
        end
    end

endmodule

// ----- hdl/apio_checker.sv -----
// ----------------------------------------------------------------------------
// apio_checker
// port-level checks of the atapi pio reply sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "atapi_pio_reply_sequencer_assert.svh"

module apio_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input apio_pkg::apio_out_t  m_data
);

    // a stalled result transaction holds its payload
    `APIO_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // completion and error both raise the irq with io and cod set
    `APIO_ASSERT_SAME(a_end_irq, aclk, aresetn, m_valid && (m_data.outcome == apio_pkg::OUTCOME_DONE || m_data.outcome == apio_pkg::OUTCOME_ERROR), m_data.raise_irq && m_data.int_reason == apio_pkg::INT_REASON_DONE)

    // a chunk keeps the data-phase reason
    `APIO_ASSERT_SAME(a_chunk_reason, aclk, aresetn, m_valid && m_data.outcome == apio_pkg::OUTCOME_CHUNK, m_data.int_reason == apio_pkg::INT_REASON_DATA)

    // an error only follows a sector read, and no chunk moves with it
    `APIO_ASSERT_SAME(a_err_read, aclk, aresetn, m_valid && m_data.outcome == apio_pkg::OUTCOME_ERROR, m_data.read_issued && m_data.chunk_bytes == 16'd0)

endmodule

bind atapi_pio_reply_sequencer apio_checker u_apio_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
